// ----- sv/fifo_reuse_object_pool_assert.svh -----
// Assertion macros shared by the object pool RTL.
`ifndef FIFO_REUSE_OBJECT_POOL_ASSERT_SVH
`define FIFO_REUSE_OBJECT_POOL_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FROP_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define FROP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/frop_pkg.sv -----
// Package with the shared types and constants of the object pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package frop_pkg;

  // Width of a handle on the request and response channels.
  localparam int unsigned HandleW = 6;

  // Default number of handles in the pool.
  localparam int unsigned PoolSizeDef = 64;

  // Request codes.
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_TRY   = 2'd1,
    ACT_FREE  = 2'd2
  } action_e;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  // Handle as carried on the channels.
  typedef logic [HandleW-1:0] handle_t;

endpackage

`default_nettype wire

// ----- sv/frop_if.sv -----
// Valid/ready channel interfaces for the object pool requests and responses.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one allocate, try-allocate or deallocate per transfer.
interface frop_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  frop_pkg::handle_t handle_in;

  modport source (output valid, action, handle_in, input ready);
  modport sink   (input valid, action, handle_in, output ready);
endinterface

// Response channel: one granted handle and status per transfer.
interface frop_rsp_if;
  logic              valid;
  logic              ready;
  frop_pkg::handle_t handle_out;
  logic [1:0]        status;

  modport source (output valid, handle_out, status, input ready);
  modport sink   (input valid, handle_out, status, output ready);
endinterface

`default_nettype wire

// ----- sv/frop_ram.sv -----
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module frop_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/fifo_reuse_object_pool.sv -----
// Top level of the object pool allocator with first-in first-out handle reuse.
//
// Hands out POOL_SIZE handles. An allocate takes the oldest freed handle from
// the free queue, or else the next never-used handle; a try-allocate only
// takes from the free queue. A deallocate is accepted only for a busy handle,
// which then joins the free queue. Every request transfer yields exactly one
// response transfer, in order. The block takes one request per cycle while
// the response register is not stalled; the request register feeds a single
// decision stage into the response register. The head of the free queue is
// prefetched from the queue RAM at the next head, with a bypass for an entry
// written in the same cycle, so back-to-back pops run at full rate. The busy
// flags live in a second RAM that is read with the handle of the request as
// it is accepted, again with a bypass for a flag written in the same cycle.
// No clearing pass is needed after reset: a busy flag counts only for a
// handle below the issued count, and every such flag was written when its
// handle was first issued.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_reuse_object_pool_assert.svh"

module fifo_reuse_object_pool #(
  parameter int unsigned POOL_SIZE = frop_pkg::PoolSizeDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frop_req_if.sink  req_i,
  frop_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(POOL_SIZE);
  localparam int unsigned CntW = $clog2(POOL_SIZE + 1);

  // Request register.
  logic                   s1_valid_q;
  logic [1:0]             s1_action_q;
  frop_pkg::handle_t      s1_handle_q;

  // Response register.
  logic                   out_valid_q, out_valid_d;
  frop_pkg::handle_t      out_handle_q;
  logic [1:0]             out_status_q;

  // Pool state.
  logic [IdxW-1:0]        head_q, head_d;
  logic [IdxW-1:0]        tail_q, tail_d;
  logic [CntW-1:0]        queue_count_q, queue_count_d;
  logic [CntW-1:0]        fresh_count_q, fresh_count_d;

  // Queue RAM access and same-cycle write bypass.
  logic                   ram_we;
  logic [IdxW-1:0]        ram_wdata;
  logic [IdxW-1:0]        ram_rdata;
  logic                   byp_hit_q, byp_hit_d;
  logic [IdxW-1:0]        byp_data_q;
  logic [IdxW-1:0]        head_val;

  // Busy flag RAM access and same-cycle write bypass.
  logic                   busy_we;
  logic [IdxW-1:0]        busy_waddr;
  logic                   busy_wdata;
  logic [IdxW-1:0]        busy_raddr;
  logic                   busy_rdata;
  logic                   busy_byp_hit_q, busy_byp_hit_d;
  logic                   busy_byp_data_q;
  logic                   busy_val;

  // Decision results.
  logic                   s1_fire;
  logic                   do_pop, do_fresh, do_push;
  logic                   issued;
  logic [IdxW-1:0]        rel_idx;
  logic [IdxW-1:0]        grant_idx;
  frop_pkg::status_e      status;

  // Handshakes: the request stage moves on whenever the response register is free.
  assign s1_fire     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_fire;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_action_q <= req_i.action;
      s1_handle_q <= req_i.handle_in;
    end
  end

  // Head of the free queue, taking a write to the prefetched slot into account.
  assign head_val = byp_hit_q ? byp_data_q : ram_rdata;

  // Busy flag of the released handle, taking a same-cycle write into account.
  assign busy_val = busy_byp_hit_q ? busy_byp_data_q : busy_rdata;

  // Released handle as a pool index; only a handle below the issued count can be busy.
  assign rel_idx = IdxW'(s1_handle_q);
  assign issued  = 32'(s1_handle_q) < 32'(fresh_count_q);

  // Request decision.
  always_comb begin
    do_pop    = 1'b0;
    do_fresh  = 1'b0;
    do_push   = 1'b0;
    grant_idx = '0;
    status    = frop_pkg::ST_INVALID;
    case (frop_pkg::action_e'(s1_action_q)) inside
      frop_pkg::ACT_ALLOC, frop_pkg::ACT_TRY: begin
        if (queue_count_q != '0) begin
          do_pop    = 1'b1;
          grant_idx = head_val;
          status    = frop_pkg::ST_OK;
        end else if (s1_action_q == frop_pkg::ACT_TRY) begin
          status = frop_pkg::ST_NONE;
        end else if (fresh_count_q < CntW'(POOL_SIZE)) begin
          do_fresh  = 1'b1;
          grant_idx = fresh_count_q[IdxW-1:0];
          status    = frop_pkg::ST_OK;
        end else begin
          status = frop_pkg::ST_EXHAUSTED;
        end
      end
      frop_pkg::ACT_FREE: begin
        if (issued && busy_val && (queue_count_q < CntW'(POOL_SIZE))) begin
          do_push = 1'b1;
          status  = frop_pkg::ST_OK;
        end
      end
      default: begin
        status = frop_pkg::ST_INVALID;
      end
    endcase
  end

  // Next pool state; only a request that moves to the response register counts.
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    queue_count_d = queue_count_q;
    fresh_count_d = fresh_count_q;
    if (s1_fire) begin
      if (do_pop) begin
        head_d        = (head_q == IdxW'(POOL_SIZE - 1)) ? '0 : head_q + IdxW'(1);
        queue_count_d = queue_count_q - CntW'(1);
      end
      if (do_fresh) begin
        fresh_count_d = fresh_count_q + CntW'(1);
      end
      if (do_push) begin
        tail_d        = (tail_q == IdxW'(POOL_SIZE - 1)) ? '0 : tail_q + IdxW'(1);
        queue_count_d = queue_count_q + CntW'(1);
      end
    end
  end

  // Queue RAM write and bypass of a write to the slot read next.
  assign ram_we    = s1_fire && do_push;
  assign ram_wdata = rel_idx;
  assign byp_hit_d = ram_we && (tail_q == head_d);

  // Busy flag write: set on a grant, cleared on a release.
  assign busy_we    = s1_fire && (do_pop || do_fresh || do_push);
  assign busy_waddr = do_pop ? head_val : (do_fresh ? fresh_count_q[IdxW-1:0] : rel_idx);
  assign busy_wdata = !do_push;

  // The busy read follows the request being accepted, or holds the waiting one.
  assign busy_raddr     = req_i.ready ? IdxW'(req_i.handle_in) : rel_idx;
  assign busy_byp_hit_d = busy_we && (busy_waddr == busy_raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q         <= '0;
      tail_q         <= '0;
      queue_count_q  <= '0;
      fresh_count_q  <= '0;
      byp_hit_q      <= 1'b0;
      busy_byp_hit_q <= 1'b0;
    end else begin
      head_q         <= head_d;
      tail_q         <= tail_d;
      queue_count_q  <= queue_count_d;
      fresh_count_q  <= fresh_count_d;
      byp_hit_q      <= byp_hit_d;
      busy_byp_hit_q <= busy_byp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q      <= ram_wdata;
    busy_byp_data_q <= busy_wdata;
  end

  // Free queue storage; the read address always follows the next head.
  frop_ram #(
    .Width (IdxW),
    .Depth (POOL_SIZE)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  // Busy flag storage, one bit per handle.
  frop_ram #(
    .Width (1),
    .Depth (POOL_SIZE)
  ) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (busy_we),
    .waddr_i (busy_waddr),
    .wdata_i (busy_wdata),
    .raddr_i (busy_raddr),
    .rdata_o (busy_rdata)
  );

  // Response register.
  always_comb begin
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_handle_q <= frop_pkg::HandleW'(grant_idx);
      out_status_q <= status;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.handle_out = out_handle_q;
  assign rsp_o.status     = out_status_q;

  // Queued handles never outnumber the handles issued so far.
  `FROP_ASSERT(a_queue_within_issued,
    queue_count_q <= fresh_count_q,
    "more handles queued than were ever issued")

  // An empty queue has its read and write positions together.
  `FROP_ASSERT(a_empty_ptrs_equal,
    (queue_count_q != '0) || (head_q == tail_q),
    "empty free queue with differing head and tail")

  // Exhausted is reported only once every handle has been issued.
  `FROP_ASSERT(a_exhausted_full,
    !out_valid_q || (out_status_q != frop_pkg::ST_EXHAUSTED) ||
    (fresh_count_q == CntW'(POOL_SIZE)),
    "pool exhausted reported before all handles were issued")

  // A pop takes exactly one handle from the queue.
  `FROP_ASSERT_NEXT(a_pop_count, s1_fire && do_pop,
    queue_count_q == $past(queue_count_q) - CntW'(1),
    "queue count did not drop by one after a pop")

endmodule

`default_nettype wire
